// ===== hw/rtl/tpb_pkg.sv =====
// Shared types and codes for the transmit ping-pong buffer controller.
`default_nettype none

package tpb_pkg;

    typedef enum logic [2:0] {
        REQ_WRITE    = 3'd0,
        REQ_COMPLETE = 3'd1,
        REQ_FAILED   = 3'd2,
        REQ_READ     = 3'd3,
        REQ_CLEAR    = 3'd4
    } req_code_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] data_byte;
        logic       last_of_write;
        logic       side;
        logic       want_zlp;
        logic [5:0] offset;
    } req_t;

    typedef struct packed {
        logic       accepted;
        logic       send_valid;
        logic       send_side;
        logic [6:0] send_length;
        logic [7:0] read_data;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tpb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tpb_ctrl.sv =====
// Control state machine that sequences capture, execution and response of an item.
`default_nettype none

module tpb_ctrl
    import tpb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output      logic busy,
    output      logic result_valid,
    output      cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        busy         = 1'b0;
        result_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                busy        = 1'b1;
                cmd.execute = 1'b1;
                state_next  = ST_RESP;
            end
            ST_RESP:
            begin
                result_valid = 1'b1;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tpb_datapath.sv =====
// Buffer state registers, byte store and result register of the ping-pong controller.
`default_nettype none

module tpb_datapath
    import tpb_pkg::*;
#(
    parameter int HALF_BYTES = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t cmd,
    input  wire req_t request,
    output      res_t result
);

    localparam int FW  = $clog2(HALF_BYTES + 1);
    localparam int MAW = $clog2(2 * HALF_BYTES);
    localparam int SW  = ((MAW > FW) ? MAW : FW) + ((MAW > 6) ? 1 : 7);
    localparam int LW  = (FW > 7) ? FW : 7;
    localparam logic [SW-1:0] HALF_S = SW'(HALF_BYTES);
    localparam logic [FW-1:0] HALF_F = FW'(HALF_BYTES);

    req_t           req_reg;
    logic [FW-1:0]  fill_reg [2];
    logic [FW-1:0]  fill_next [2];
    logic [1:0]     sending_reg;
    logic [1:0]     sending_next;
    logic           cur_side_reg;
    logic           cur_side_next;
    logic           open_reg;
    logic           open_next;
    logic           wrote_reg;
    logic           wrote_next;
    res_t           res_reg;
    res_t           res_next;
    logic           rd_ok_reg;
    logic           rd_ok_next;

    logic           w;
    logic           o;
    logic           can_take;
    logic           wrote_now;
    logic [FW-1:0]  fill_w_new;
    logic [SW-1:0]  waddr_wide;
    logic [SW-1:0]  raddr_wide;
    logic           ram_we;
    logic           ram_re;
    logic [7:0]     ram_q;
    req_code_t      code;

    tpb_ram #(
        .WIDTH (8),
        .DEPTH (2 * HALF_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (MAW'(waddr_wide)),
        .wdata (req_reg.data_byte),
        .re    (ram_re),
        .raddr (MAW'(raddr_wide)),
        .rdata (ram_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= request;
        end
        if (cmd.execute)
        begin
            res_reg   <= res_next;
            rd_ok_reg <= rd_ok_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg[0]  <= '0;
            fill_reg[1]  <= '0;
            sending_reg  <= '0;
            cur_side_reg <= 1'b0;
            open_reg     <= 1'b0;
            wrote_reg    <= 1'b0;
        end
        else if (cmd.execute)
        begin
            fill_reg[0]  <= fill_next[0];
            fill_reg[1]  <= fill_next[1];
            sending_reg  <= sending_next;
            cur_side_reg <= cur_side_next;
            open_reg     <= open_next;
            wrote_reg    <= wrote_next;
        end
    end

    always_comb
    begin
        code          = req_code_t'(req_reg.req_type);
        fill_next[0]  = fill_reg[0];
        fill_next[1]  = fill_reg[1];
        sending_next  = sending_reg;
        cur_side_next = cur_side_reg;
        open_next     = open_reg;
        wrote_next    = wrote_reg;
        res_next      = '0;
        rd_ok_next    = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        // The write half is fixed at the first byte of a write.
        w          = open_reg ? cur_side_reg : sending_reg[0];
        o          = ~req_reg.side;
        can_take   = !sending_reg[w] && (fill_reg[w] < HALF_F);
        wrote_now  = (open_reg && wrote_reg) || can_take;
        fill_w_new = fill_reg[w] + FW'(can_take);
        waddr_wide = (w ? HALF_S : '0) + SW'(fill_reg[w]);
        raddr_wide = (req_reg.side ? HALF_S : '0) + SW'(req_reg.offset);

        unique case (code)
            REQ_WRITE:
            begin
                ram_we            = cmd.execute && can_take;
                res_next.accepted = can_take;
                fill_next[w]      = fill_w_new;
                cur_side_next     = w;
                if (req_reg.last_of_write)
                begin
                    open_next  = 1'b0;
                    wrote_next = 1'b0;
                    if (wrote_now && !sending_reg[w] && fill_reg[~w] == '0
                        && !sending_reg[~w])
                    begin
                        sending_next[w]      = 1'b1;
                        res_next.send_valid  = 1'b1;
                        res_next.send_side   = w;
                        res_next.send_length = 7'(LW'(fill_w_new));
                    end
                end
                else
                begin
                    open_next  = 1'b1;
                    wrote_next = wrote_now;
                end
            end
            REQ_COMPLETE:
            begin
                if (req_reg.want_zlp && fill_reg[o] == '0 && !sending_reg[o])
                begin
                    res_next.send_valid = 1'b1;
                    res_next.send_side  = req_reg.side;
                end
                else
                begin
                    fill_next[req_reg.side]    = '0;
                    sending_next[req_reg.side] = 1'b0;
                    if (fill_reg[o] != '0 && !sending_reg[o])
                    begin
                        sending_next[o]      = 1'b1;
                        res_next.send_valid  = 1'b1;
                        res_next.send_side   = o;
                        res_next.send_length = 7'(LW'(fill_reg[o]));
                    end
                end
            end
            REQ_FAILED:
            begin
                sending_next[req_reg.side] = 1'b0;
            end
            REQ_READ:
            begin
                ram_re     = cmd.execute;
                rd_ok_next = (int'(req_reg.offset) < HALF_BYTES);
            end
            REQ_CLEAR:
            begin
                fill_next[0]  = '0;
                fill_next[1]  = '0;
                sending_next  = '0;
                cur_side_next = 1'b0;
                open_next     = 1'b0;
                wrote_next    = 1'b0;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    // Read data comes from the RAM output register, forced to zero when the offset lies outside the half.
    always_comb
    begin
        result           = res_reg;
        result.read_data = rd_ok_reg ? ram_q : 8'h00;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tx_pingpong_buffer_ctrl.sv =====
// Top level of the transmit ping-pong buffer controller for a bulk endpoint.
// Each item is captured into the request register, then executed into the result register.
// A new item can be started in the respond cycle of the one before it; the execute cycle (one
// read-modify-write of the fill level and one access to the byte store RAM) sets the pace.
// Reset clears fill levels, sending marks and the open write; the byte store is not cleared.
// The receiver cannot stall: the result is valid for exactly one cycle.
`default_nettype none

module tx_pingpong_buffer_ctrl
    import tpb_pkg::*;
#(
    parameter int HALF_BYTES = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output      logic busy,
    input  wire req_t request,
    output      logic result_valid,
    output      res_t result
);

    // The controller steps each item through capture, execute and respond.
    // An item may be started in the respond cycle of the one before it, so
    // busy is high only during the execute cycle.
    cmd_t cmd;

    tpb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    // The datapath holds both buffer halves, their fill levels and sending
    // marks, the state of the open write, and the registered result.
    tpb_datapath #(
        .HALF_BYTES (HALF_BYTES)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .result  (result)
    );

endmodule

`default_nettype wire
